>>> hw/rtl/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/stok_pkg.sv
// Shared types, codes, keyword tables and character classes for the tokenizer.
package stok_pkg;

   localparam int OFFSET_BITS_DEF = 32;
   localparam int LINE_BITS_DEF   = 24;
   localparam int LENGTH_BITS_DEF = 16;

   // token classes
   localparam logic [2:0] TC_SINGLE = 3'd0;
   localparam logic [2:0] TC_INT    = 3'd1;
   localparam logic [2:0] TC_IDENT  = 3'd2;
   localparam logic [2:0] TC_IF     = 3'd3;
   localparam logic [2:0] TC_ELSE   = 3'd4;
   localparam logic [2:0] TC_WHILE  = 3'd5;
   localparam logic [2:0] TC_RETURN = 3'd6;
   localparam logic [2:0] TC_EOF    = 3'd7;

   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   // response queue
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PTR_BITS = 2;
   localparam int RSPQ_CNT_BITS = 3;

   // keyword text, zero padded to eight bytes: if, else, while, return
   localparam logic [7:0] KW_TEXT [4][8] = '{
      '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00},
      '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E, 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [4] = '{3'd2, 3'd4, 3'd5, 3'd6};

   typedef struct packed {
      logic [2:0]  token_class;
      logic [7:0]  char_code;
      logic [15:0] token_length;
      logic [31:0] start_offset;
      logic [23:0] token_line;
      logic        last;
   } rsp_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return c >= 8'h61 && c <= 8'h7A;
   endfunction

   function automatic logic is_ident_cont(input logic [7:0] c);
      return is_digit(c) || is_lower(c) || (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDERSCORE);
   endfunction

endpackage

>>> hw/rtl/stok_scan.sv
// Scanner state and combinational step logic: one byte in, up to two tokens out.
module stok_scan #(
   parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEF,
   parameter int LINE_BITS   = stok_pkg::LINE_BITS_DEF,
   parameter int LENGTH_BITS = stok_pkg::LENGTH_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        ch,
   output stok_pkg::rsp_type res0,
   output stok_pkg::rsp_type res1,
   output logic [1:0]        res_count
);

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_SLASH   = 3'd1;
   localparam logic [2:0] MODE_COMMENT = 3'd2;
   localparam logic [2:0] MODE_INT     = 3'd3;
   localparam logic [2:0] MODE_IDENT   = 3'd4;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
   localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);

   logic [2:0]             mode_ff, mode_in;
   logic [LENGTH_BITS-1:0] run_length_ff, run_length_in;
   logic [OFFSET_BITS-1:0] run_start_ff, run_start_in;
   logic [OFFSET_BITS-1:0] byte_pos_ff, byte_pos_in;
   logic [LINE_BITS-1:0]   line_count_ff, line_count_in;
   logic [LINE_BITS-1:0]   run_line_ff, run_line_in;
   logic [3:0]             kw_alive_ff, kw_alive_in;
   logic [7:0]             first_byte_ff, first_byte_in;

   // zero-extended views, low bits feed the fixed-width result fields
   logic [OFFSET_BITS+31:0] run_start_x, byte_pos_x;
   logic [LINE_BITS+23:0]   run_line_x, line_count_x;
   logic [LENGTH_BITS+15:0] run_length_x;

   logic              fresh, has_pend, has_fresh;
   logic [2:0]        run_class;
   stok_pkg::rsp_type pend_res, fresh_res;

   assign run_start_x  = {32'd0, run_start_ff};
   assign byte_pos_x   = {32'd0, byte_pos_ff};
   assign run_line_x   = {24'd0, run_line_ff};
   assign line_count_x = {24'd0, line_count_ff};
   assign run_length_x = {16'd0, run_length_ff};

   // class of the pending integer or identifier run
   always_comb begin
      run_class = stok_pkg::TC_INT;
      if (mode_ff == MODE_IDENT) begin
         run_class = stok_pkg::TC_IDENT;
         for (int k = 0; k < 4; k++) begin
            if (kw_alive_ff[k] && run_length_ff == LENGTH_BITS'(stok_pkg::KW_LEN[k])) begin
               run_class = stok_pkg::TC_IF + 3'(k);
            end
         end
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      run_length_in = run_length_ff;
      run_start_in  = run_start_ff;
      byte_pos_in   = byte_pos_ff + OFFSET_BITS'(1);
      line_count_in = line_count_ff;
      run_line_in   = run_line_ff;
      kw_alive_in   = kw_alive_ff;
      first_byte_in = first_byte_ff;
      fresh         = 1'b1;
      has_pend      = 1'b0;
      has_fresh     = 1'b0;

      pend_res.token_class  = run_class;
      pend_res.char_code    = first_byte_ff;
      pend_res.token_length = run_length_x[15:0];
      pend_res.start_offset = run_start_x[31:0];
      pend_res.token_line   = run_line_x[23:0];
      pend_res.last         = 1'b0;

      fresh_res.token_class  = stok_pkg::TC_SINGLE;
      fresh_res.char_code    = ch;
      fresh_res.token_length = 16'd1;
      fresh_res.start_offset = byte_pos_x[31:0];
      fresh_res.token_line   = line_count_x[23:0];
      fresh_res.last         = 1'b1;

      unique case (mode_ff)
         MODE_COMMENT: begin
            if (ch != stok_pkg::CH_NUL && ch != stok_pkg::CH_NEWLINE) begin
               fresh = 1'b0;
            end
         end
         MODE_SLASH: begin
            if (ch == stok_pkg::CH_SLASH) begin
               mode_in = MODE_COMMENT;
               fresh   = 1'b0;
            end else begin
               has_pend               = 1'b1;
               pend_res.token_class   = stok_pkg::TC_SINGLE;
               pend_res.char_code     = stok_pkg::CH_SLASH;
               pend_res.token_length  = 16'd1;
            end
         end
         MODE_INT: begin
            if (stok_pkg::is_digit(ch)) begin
               if (run_length_ff != LEN_MAX) begin
                  run_length_in = run_length_ff + LEN_ONE;
               end
               fresh = 1'b0;
            end else begin
               has_pend = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (stok_pkg::is_ident_cont(ch)) begin
               for (int k = 0; k < 4; k++) begin
                  if (!(run_length_ff < LENGTH_BITS'(stok_pkg::KW_LEN[k]) &&
                        stok_pkg::KW_TEXT[k][run_length_ff[2:0]] == ch)) begin
                     kw_alive_in[k] = 1'b0;
                  end
               end
               if (run_length_ff != LEN_MAX) begin
                  run_length_in = run_length_ff + LEN_ONE;
               end
               fresh = 1'b0;
            end else begin
               has_pend = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (fresh) begin
         mode_in = MODE_IDLE;
         if (ch == stok_pkg::CH_NUL) begin
            has_fresh              = 1'b1;
            fresh_res.token_class  = stok_pkg::TC_EOF;
            fresh_res.char_code    = 8'd0;
            fresh_res.token_length = 16'd0;
            // restart all counters
            run_length_in = '0;
            run_start_in  = '0;
            byte_pos_in   = '0;
            line_count_in = LINE_ONE;
            run_line_in   = LINE_ONE;
            kw_alive_in   = 4'hF;
            first_byte_in = 8'd0;
         end else if (stok_pkg::is_space(ch)) begin
            if (ch == stok_pkg::CH_NEWLINE && line_count_ff != LINE_MAX) begin
               line_count_in = line_count_ff + LINE_ONE;
            end
         end else if (ch == stok_pkg::CH_SLASH) begin
            mode_in      = MODE_SLASH;
            run_start_in = byte_pos_ff;
            run_line_in  = line_count_ff;
         end else if (stok_pkg::is_digit(ch) || stok_pkg::is_lower(ch) ||
                      ch == stok_pkg::CH_UNDERSCORE) begin
            mode_in       = stok_pkg::is_digit(ch) ? MODE_INT : MODE_IDENT;
            run_start_in  = byte_pos_ff;
            run_line_in   = line_count_ff;
            run_length_in = LEN_ONE;
            first_byte_in = ch;
            for (int k = 0; k < 4; k++) begin
               kw_alive_in[k] = (stok_pkg::KW_TEXT[k][0] == ch);
            end
         end else begin
            has_fresh = 1'b1;
         end
      end
   end

   always_comb begin
      res0      = has_pend ? pend_res : fresh_res;
      res0.last = !(has_pend && has_fresh);
      res1      = fresh_res;
      res_count = step ? ({1'b0, has_pend} + {1'b0, has_fresh}) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         run_length_ff <= '0;
         run_start_ff  <= '0;
         byte_pos_ff   <= '0;
         line_count_ff <= LINE_ONE;
         run_line_ff   <= LINE_ONE;
         kw_alive_ff   <= 4'hF;
         first_byte_ff <= 8'd0;
      end else if (step) begin
         mode_ff       <= mode_in;
         run_length_ff <= run_length_in;
         run_start_ff  <= run_start_in;
         byte_pos_ff   <= byte_pos_in;
         line_count_ff <= line_count_in;
         run_line_ff   <= run_line_in;
         kw_alive_ff   <= kw_alive_in;
         first_byte_ff <= first_byte_in;
      end
   end

endmodule

>>> hw/rtl/stok_rspq.sv
// Four-entry token queue: pushes up to two tokens a cycle, pops one.
module stok_rspq (
   input  logic              clock,
   input  logic              reset,
   input  stok_pkg::rsp_type push0,
   input  stok_pkg::rsp_type push1,
   input  logic [1:0]        push_count,
   input  logic              pop,
   output stok_pkg::rsp_type head,
   output logic              not_empty,
   output logic              room2
);

   stok_pkg::rsp_type entry_ff [stok_pkg::RSPQ_DEPTH];

   logic [stok_pkg::RSPQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [stok_pkg::RSPQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [stok_pkg::RSPQ_CNT_BITS-1:0] count_ff, count_in;
   logic [stok_pkg::RSPQ_PTR_BITS-1:0] wr_next;

   assign wr_next   = wr_ptr_ff + stok_pkg::RSPQ_PTR_BITS'(1);
   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign room2     = (count_ff <= stok_pkg::RSPQ_CNT_BITS'(stok_pkg::RSPQ_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + stok_pkg::RSPQ_PTR_BITS'(push_count);
      rd_ptr_in = rd_ptr_ff + stok_pkg::RSPQ_PTR_BITS'(pop);
      count_in  = count_ff + stok_pkg::RSPQ_CNT_BITS'(push_count)
                  - stok_pkg::RSPQ_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_next] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/source_tokenizer.sv
// Top level of the streaming source tokenizer.
//
// Input channel (req_): one source byte per transfer on req_ch; byte zero ends
// the source, emits an end-of-file token and restarts offsets and line count.
// Output channel (rsp_): one token per transfer with class, first byte, length,
// start offset, start line and rsp_last, which marks the final token caused by
// one input byte. A byte may cause zero, one or two tokens.
// Path: a byte taken on req_ sits in the input register, is scanned and queued
// once the queue has two free entries, and its first token then shows on rsp_
// from the queue head, which is read combinationally.
// Throughput: one byte per cycle while the receiver keeps up; a byte that
// causes two tokens needs two output transfers, so the output port sets the rate.
// Stall: tokens wait in a four-entry queue; the scanner steps only while two
// entries are free, and req_ready drops once the input register is stuck.
// Reset: synchronous; queue empties, scanner returns to idle with line one and
// offset zero.
module source_tokenizer #(
   parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEF,
   parameter int LINE_BITS   = stok_pkg::LINE_BITS_DEF,
   parameter int LENGTH_BITS = stok_pkg::LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_token_class,
   output logic [7:0]  rsp_char_code,
   output logic [15:0] rsp_token_length,
   output logic [31:0] rsp_start_offset,
   output logic [23:0] rsp_token_line,
   output logic        rsp_last
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_ch_ff;
   logic              step;
   logic              room2;
   logic [1:0]        res_count;
   stok_pkg::rsp_type res0, res1, head;

   // Advance the scanner only when the queue can absorb a worst-case byte.
   assign step      = in_valid_ff && room2;
   assign req_ready = !in_valid_ff || room2;

   // Input register: load on transfer, drop once scanned.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload needs no reset; hold it until the next transfer.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff <= req_ch;
      end
   end

   stok_scan #(
      .OFFSET_BITS (OFFSET_BITS),
      .LINE_BITS   (LINE_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .ch        (in_ch_ff),
      .res0      (res0),
      .res1      (res1),
      .res_count (res_count)
   );

   stok_rspq u_rspq (
      .clock      (clock),
      .reset      (reset),
      .push0      (res0),
      .push1      (res1),
      .push_count (res_count),
      .pop        (rsp_valid && rsp_ready),
      .head       (head),
      .not_empty  (rsp_valid),
      .room2      (room2)
   );

   // Present the queue head.
   assign rsp_token_class  = head.token_class;
   assign rsp_char_code    = head.char_code;
   assign rsp_token_length = head.token_length;
   assign rsp_start_offset = head.start_offset;
   assign rsp_token_line   = head.token_line;
   assign rsp_last         = head.last;

endmodule

>>> hw/rtl/stok_checker.sv
// Port-level checker for the tokenizer and its bind to the top level.
`include "assert_macros.svh"

module stok_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_token_class,
   input logic [7:0]  rsp_char_code,
   input logic [15:0] rsp_token_length,
   input logic [31:0] rsp_start_offset,
   input logic [23:0] rsp_token_line,
   input logic        rsp_last
);

   logic        rsp_wait, rsp_eof, rsp_single, rsp_if;
   logic        eof_shape, if_shape;
   logic [83:0] rsp_fields;

   assign rsp_wait   = rsp_valid && !rsp_ready;
   assign rsp_eof    = rsp_valid && rsp_token_class == stok_pkg::TC_EOF;
   assign rsp_single = rsp_valid && rsp_token_class == stok_pkg::TC_SINGLE;
   assign rsp_if     = rsp_valid && rsp_token_class == stok_pkg::TC_IF;
   assign eof_shape  = rsp_token_length == 16'd0 && rsp_char_code == 8'd0 && rsp_last;
   assign if_shape   = rsp_token_length == 16'd2 && rsp_char_code == 8'h69;
   assign rsp_fields = {rsp_token_class, rsp_char_code, rsp_token_length,
                        rsp_start_offset, rsp_token_line, rsp_last};

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_fields))

   `ASSERT_IMPLY(a_eof_shape, clock, reset, rsp_eof, eof_shape)

   `ASSERT_IMPLY(a_single_len, clock, reset, rsp_single, rsp_token_length == 16'd1)

   `ASSERT_IMPLY(a_kw_if_len, clock, reset, rsp_if, if_shape)

   `ASSERT_IMPLY(a_idle_after_reset, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind source_tokenizer stok_checker u_stok_checker (.*);

>>> tb/source_tokenizer_test.sv
// Self-checking testbench for the streaming source tokenizer.
`timescale 1ns / 1ps

module source_tokenizer_test;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either channel
   localparam int DRAIN_CYCLES   = 20;    // quiet cycles after the last expected token
   localparam int PHASE_BYTES    = 340;   // random source bytes per pacing phase

   localparam logic [15:0] LENGTH_CAP = 16'hFFFF;
   localparam logic [23:0] LINE_CAP   = 24'hFFFFFF;

   // scanner modes of the predictor
   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_SLASH,
      SCAN_COMMENT,
      SCAN_INT,
      SCAN_IDENT
   } scan_mode_e;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_token_class;
   logic [7:0]  rsp_char_code;
   logic [15:0] rsp_token_length;
   logic [31:0] rsp_start_offset;
   logic [23:0] rsp_token_line;
   logic        rsp_last;

   source_tokenizer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ch           (req_ch),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_class  (rsp_token_class),
      .rsp_char_code    (rsp_char_code),
      .rsp_token_length (rsp_token_length),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_line   (rsp_token_line),
      .rsp_last         (rsp_last)
   );

   always #2 clock = ~clock;

   // Source bytes waiting for the driver, and tokens still owed by the block.
   logic [7:0]        pending_bytes[$];
   stok_pkg::rsp_type expected_tokens[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int queued_count   = 0;
   int bytes_sent     = 0;
   int tokens_checked = 0;
   int eof_seen       = 0;
   int idle_cycles    = 0;

   string kw_word[4]  = '{"if", "else", "while", "return"};
   string word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
   string punct_chars = "(){};+-*=<>,.!&|[]#";
   string blank_chars = " \t\n\v\f\r";

   // ------------------------------------------------------------------
   // Token predictor: mirrors the scanner state byte by byte.
   // ------------------------------------------------------------------
   scan_mode_e  scan_mode;
   logic [15:0] run_len;
   logic [31:0] run_off;
   logic [31:0] byte_pos;
   logic [23:0] cur_line;
   logic [23:0] run_line;
   logic [3:0]  kw_live;
   logic [7:0]  lead_byte;

   // tokens produced by the byte under evaluation, at most two
   stok_pkg::rsp_type step_out[2];
   int                step_n;

   function automatic bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic bit is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_word_start(logic [7:0] c);
      return (c >= "a" && c <= "z") || c == stok_pkg::CH_UNDERSCORE;
   endfunction

   function automatic bit is_word_char(logic [7:0] c);
      return is_num(c) || is_word_start(c) || (c >= "A" && c <= "Z");
   endfunction

   function void clear_scan();
      scan_mode = SCAN_IDLE;
      run_len   = '0;
      run_off   = '0;
      byte_pos  = '0;
      cur_line  = 24'd1;
      run_line  = 24'd1;
      kw_live   = 4'hF;
      lead_byte = '0;
   endfunction

   function void note_token(logic [2:0] cls, logic [7:0] code, logic [15:0] len,
                            logic [31:0] off, logic [23:0] line);
      step_out[step_n] = '{token_class: cls, char_code: code, token_length: len,
                           start_offset: off, token_line: line, last: 1'b0};
      step_n++;
   endfunction

   // Close the current integer or identifier run; a keyword needs the exact length.
   function void emit_run();
      logic [2:0] cls;
      cls = stok_pkg::TC_INT;
      if (scan_mode == SCAN_IDENT) begin
         cls = stok_pkg::TC_IDENT;
         for (int k = 0; k < 4; k++)
            if (kw_live[k] && run_len == 16'(kw_word[k].len()))
               cls = stok_pkg::TC_IF + 3'(k);
      end
      note_token(cls, lead_byte, run_len, run_off, run_line);
   endfunction

   function void scan_byte(logic [7:0] c);
      bit                fresh;
      bit                at_end;
      stok_pkg::rsp_type tok;
      fresh  = 1'b1;
      at_end = 1'b0;
      step_n = 0;
      case (scan_mode)
         SCAN_COMMENT: begin
            if (c != stok_pkg::CH_NUL && c != stok_pkg::CH_NEWLINE)
               fresh = 1'b0;
         end
         SCAN_SLASH: begin
            if (c == stok_pkg::CH_SLASH) begin
               scan_mode = SCAN_COMMENT;
               fresh = 1'b0;
            end else begin
               note_token(stok_pkg::TC_SINGLE, stok_pkg::CH_SLASH, 16'd1, run_off, run_line);
            end
         end
         SCAN_INT: begin
            if (is_num(c)) begin
               if (run_len != LENGTH_CAP) run_len++;
               fresh = 1'b0;
            end else begin
               emit_run();
            end
         end
         SCAN_IDENT: begin
            if (is_word_char(c)) begin
               // drop every keyword this byte no longer matches
               for (int k = 0; k < 4; k++)
                  if (!(run_len < 16'(kw_word[k].len()) && kw_word[k][run_len] == c))
                     kw_live[k] = 1'b0;
               if (run_len != LENGTH_CAP) run_len++;
               fresh = 1'b0;
            end else begin
               emit_run();
            end
         end
         default: ;
      endcase

      if (fresh) begin
         scan_mode = SCAN_IDLE;
         if (c == stok_pkg::CH_NUL) begin
            note_token(stok_pkg::TC_EOF, 8'h00, 16'd0, byte_pos, cur_line);
            clear_scan();
            at_end = 1'b1;
         end else if (is_blank(c)) begin
            if (c == stok_pkg::CH_NEWLINE && cur_line != LINE_CAP) cur_line++;
         end else if (c == stok_pkg::CH_SLASH) begin
            scan_mode = SCAN_SLASH;
            run_off   = byte_pos;
            run_line  = cur_line;
         end else if (is_num(c) || is_word_start(c)) begin
            scan_mode = is_num(c) ? SCAN_INT : SCAN_IDENT;
            run_off   = byte_pos;
            run_line  = cur_line;
            run_len   = 16'd1;
            lead_byte = c;
            for (int k = 0; k < 4; k++)
               kw_live[k] = (kw_word[k][0] == c);
         end else begin
            note_token(stok_pkg::TC_SINGLE, c, 16'd1, byte_pos, cur_line);
         end
      end

      if (!at_end) byte_pos++;

      for (int i = 0; i < step_n; i++) begin
         tok = step_out[i];
         tok.last = (i == step_n - 1);
         expected_tokens.push_back(tok);
      end
   endfunction

   initial clear_scan();

   // ------------------------------------------------------------------
   // Driver: one byte per transfer; valid holds until the byte is taken.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_ch    <= 8'h00;
      end else begin
         if (req_valid && req_ready) begin
            scan_byte(req_ch);
            bytes_sent++;
         end
         // pick the next byte only when nothing is on offer or the offered byte is taken
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_ch    <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare each token transfer with the oldest prediction.
   // ------------------------------------------------------------------
   function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d (0x%0h), got %0d (0x%0h)", name, want, want, got, got);
         fail_count++;
      end
   endfunction

   function void check_token();
      stok_pkg::rsp_type want;
      if (expected_tokens.size() == 0) begin
         $error("token transfer with none expected: class %0d offset %0d",
                rsp_token_class, rsp_start_offset);
         fail_count++;
      end else begin
         want = expected_tokens.pop_front();
         check_field("token_class", 32'(want.token_class), 32'(rsp_token_class));
         check_field("char_code", 32'(want.char_code), 32'(rsp_char_code));
         check_field("token_length", 32'(want.token_length), 32'(rsp_token_length));
         check_field("start_offset", want.start_offset, rsp_start_offset);
         check_field("token_line", 32'(want.token_line), 32'(rsp_token_line));
         check_field("last", 32'(want.last), 32'(rsp_last));
         tokens_checked++;
         if (want.token_class == stok_pkg::TC_EOF) eof_seen++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_token();
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: abort when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d tokens outstanding",
                  idle_cycles, expected_tokens.size());
         $display("** source_tokenizer: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus builders.
   // ------------------------------------------------------------------
   function void add_byte(logic [7:0] b);
      pending_bytes.push_back(b);
      queued_count++;
   endfunction

   function void add_text(string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endfunction

   function void add_piece();
      int    k;
      int    n;
      byte   b;
      case ($urandom_range(15))
         0: add_text(kw_word[$urandom_range(3)]);
         1: begin
            // near miss of a keyword: cut short or run on
            k = $urandom_range(3);
            if ($urandom_range(1))
               add_text(kw_word[k].substr(0, kw_word[k].len() - 2));
            else begin
               add_text(kw_word[k]);
               add_byte(word_chars[$urandom_range(word_chars.len() - 1)]);
            end
         end
         2, 3: begin
            add_byte($urandom_range(1) ? stok_pkg::CH_UNDERSCORE
                                       : 8'($urandom_range("a", "z")));
            n = $urandom_range(8);
            repeat (n) add_byte(word_chars[$urandom_range(word_chars.len() - 1)]);
         end
         4: repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range("0", "9")));
         5, 6: add_byte(blank_chars[$urandom_range(blank_chars.len() - 1)]);
         7: begin
            // comment body takes any byte but newline and end of source
            add_text("//");
            repeat ($urandom_range(6)) begin
               b = 8'($urandom_range(1, 255));
               add_byte(b == stok_pkg::CH_NEWLINE ? 8'h0B : b);
            end
            if ($urandom_range(7) != 0) add_byte(stok_pkg::CH_NEWLINE);
         end
         8: add_byte(stok_pkg::CH_SLASH);
         9: add_byte(punct_chars[$urandom_range(punct_chars.len() - 1)]);
         10: add_byte(8'($urandom_range("A", "Z")));
         11: add_byte(8'($urandom_range(128, 255)));
         12: repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(1, 255)));
         13: repeat ($urandom_range(1, 3)) add_byte(stok_pkg::CH_NEWLINE);
         default: add_byte(" ");
      endcase
   endfunction

   // Well-formed sources with random content, mostly closed by an end byte.
   function void add_sources(int budget);
      int start;
      start = queued_count;
      while (queued_count - start < budget) begin
         repeat ($urandom_range(3, 25)) add_piece();
         if ($urandom_range(9) != 0) add_byte(stok_pkg::CH_NUL);
      end
   endfunction

   // Hold until every byte is taken and every predicted token has come back.
   task automatic settle();
      while (pending_bytes.size() != 0 || req_valid || expected_tokens.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed source: all keywords, a run broken by '/', a comment, an
      // uppercase start, underscore run cut by a high byte, byte extremes.
      add_text("if else\nwhile return/9//c\nZ_");
      add_byte(8'hFF);
      add_byte(8'h01);
      add_byte(8'h80);
      add_byte(stok_pkg::CH_NUL);
      settle();

      // Random sources under each pacing mix; drain fully between mixes.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         add_sources(PHASE_BYTES);
         settle();
      end

      // flush any unterminated source
      add_byte(stok_pkg::CH_NUL);
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d source bytes over %0d sources and checked %0d tokens,",
               bytes_sent, eof_seen, tokens_checked);
      $display("with keyword near misses, comments, both-side stalls and two-token bytes.");
      if (fail_count == 0) begin
         $display("** source_tokenizer: PASSED **");
      end else begin
         $display("** source_tokenizer: FAILED **");
      end
      $finish;
   end

endmodule
